@@ src/pst_pkg.sv @@
// Shared types and codes of the periodic task scheduler table.
`timescale 1ns / 1ps

package pst_pkg;

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_DELAY  = 2'd2,
    MODE_RUN    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_DELAY,
    WR_FIRE,
    WR_SHIFT,
    WR_APPEND
  } wr_sel_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_PEND,
    OUT_FINAL
  } out_sel_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] interval;
    logic [31:0] last_run;
    logic [31:0] delay_until;
  } entry_t;

  typedef struct packed {
    logic     latch;
    logic     rd_en;
    logic     rd_next;
    wr_sel_e  wr_sel;
    logic     idx_inc;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     ok_set;
    logic     pend_set;
    out_sel_e out_sel;
  } pst_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  create_bad;
    logic  cnt_zero;
    logic  match;
    logic  due;
    logic  last_idx;
    logic  next_last;
    logic  pend_vld;
    logic  out_free;
  } pst_stat_t;

endpackage

@@ src/periodic_task_scheduler_table.sv @@
// Periodic task scheduler table with one table read port: each table entry visited is read, then evaluated.
// Create, delay and delete search the live entries; delete then shifts the later entries down one slot.
// Run visits every live entry and also holds while a pending report cannot be pushed out; every mode
// holds its final result while the result side stalls. One item is in work at a time; the next can be
// taken in the cycle after the final result is loaded. Reset clears the entry count, the controller
// and the result valid; table contents are not cleared and are only read below the count.
`timescale 1ns / 1ps

module periodic_task_scheduler_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic signed [7:0] task_id_i,
  input  logic [31:0]       interval_ms_i,
  input  logic [31:0]       delay_ms_i,
  input  logic [31:0]       now_ms_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              status_ok_o,
  output logic              fired_o,
  output logic signed [7:0] fired_id_o,
  output logic              last_o
);
  import pst_pkg::*;

  pst_cmd_t  cmd;
  pst_stat_t stat;

  pst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pst_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .mode_i        (mode_i),
    .task_id_i     (task_id_i),
    .interval_ms_i (interval_ms_i),
    .delay_ms_i    (delay_ms_i),
    .now_ms_i      (now_ms_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_ok_o   (status_ok_o),
    .fired_o       (fired_o),
    .fired_id_o    (fired_id_o),
    .last_o        (last_o)
  );

endmodule

@@ src/pst_datapath.sv @@
// Datapath: task table memory, entry count, walk index and result register.
`timescale 1ns / 1ps

module pst_datapath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pst_pkg::pst_cmd_t  cmd_i,
  output pst_pkg::pst_stat_t stat_o,
  input  logic [1:0]         mode_i,
  input  logic signed [7:0]  task_id_i,
  input  logic [31:0]        interval_ms_i,
  input  logic [31:0]        delay_ms_i,
  input  logic [31:0]        now_ms_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic               status_ok_o,
  output logic               fired_o,
  output logic signed [7:0]  fired_id_o,
  output logic               last_o
);
  import pst_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_q;

  mode_e       mode_q;
  logic [7:0]  id_q;
  logic [31:0] interval_q;
  logic [31:0] delay_q;
  logic [31:0] now_q;

  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pend_vld_q, pend_vld_d;
  logic [7:0]       pend_id_q;
  logic             ok_q, ok_d;
  logic             out_valid_q, out_valid_d;
  logic             status_ok_q, fired_q, last_q;
  logic [7:0]       fired_id_q;

  logic [CNT_W-1:0] idx_nxt;
  logic [CNT_W:0]   idx_nxt2;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             wr_en;
  entry_t           wr_data;
  logic [31:0]      elapsed;
  logic             out_free;

  assign idx_nxt  = idx_q + 1'b1;
  assign idx_nxt2 = {1'b0, idx_q} + (CNT_W + 1)'(2);
  assign rd_addr  = cmd_i.rd_next ? idx_nxt[IDX_W-1:0] : idx_q[IDX_W-1:0];
  assign elapsed  = now_q - rd_q.last_run;
  assign out_free = !out_valid_q || !out_stall_i;

  // Build the word written back to the table.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_q[IDX_W-1:0];
    wr_data = rd_q;
    unique case (cmd_i.wr_sel)
      WR_NONE:  wr_en = 1'b0;
      WR_DELAY: wr_data.delay_until = now_q + delay_q;
      WR_FIRE:  wr_data.last_run = now_q;
      WR_SHIFT: wr_data = rd_q;
      WR_APPEND: begin
        wr_addr             = count_q[IDX_W-1:0];
        wr_data.id          = id_q;
        wr_data.interval    = interval_q;
        wr_data.last_run    = now_q;
        wr_data.delay_until = '0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q     <= mode_e'(mode_i);
      id_q       <= task_id_i;
      interval_q <= interval_ms_i;
      delay_q    <= delay_ms_i;
      now_q      <= now_ms_i;
    end
    if (cmd_i.pend_set) begin
      pend_id_q <= rd_q.id;
    end
  end

  always_comb begin
    idx_d      = idx_q;
    count_d    = count_q;
    pend_vld_d = pend_vld_q;
    ok_d       = ok_q;
    if (cmd_i.latch) begin
      idx_d      = '0;
      pend_vld_d = 1'b0;
      ok_d       = 1'b0;
    end
    if (cmd_i.idx_inc)  idx_d = idx_nxt;
    if (cmd_i.cnt_inc)  count_d = count_q + 1'b1;
    if (cmd_i.cnt_dec)  count_d = count_q - 1'b1;
    if (cmd_i.ok_set)   ok_d = 1'b1;
    if (cmd_i.pend_set) pend_vld_d = 1'b1;
  end

  // Result register: drop on transfer, load when the controller emits.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.out_sel != OUT_NONE) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.out_sel)
      OUT_NONE: ;
      OUT_PEND: begin
        status_ok_q <= 1'b1;
        fired_q     <= 1'b1;
        fired_id_q  <= pend_id_q;
        last_q      <= 1'b0;
      end
      OUT_FINAL: begin
        last_q <= 1'b1;
        if (mode_q == MODE_RUN && pend_vld_q) begin
          status_ok_q <= 1'b1;
          fired_q     <= 1'b1;
          fired_id_q  <= pend_id_q;
        end else begin
          status_ok_q <= (mode_q == MODE_RUN) ? 1'b0 : ok_q;
          fired_q     <= 1'b0;
          fired_id_q  <= '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      count_q     <= '0;
      pend_vld_q  <= 1'b0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      count_q     <= count_d;
      pend_vld_q  <= pend_vld_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    stat_o.mode       = mode_q;
    stat_o.create_bad = id_q[7] || (interval_q == '0) ||
                        (count_q == CNT_W'(TABLE_DEPTH));
    stat_o.cnt_zero   = (count_q == '0);
    stat_o.match      = (rd_q.id == id_q);
    stat_o.due        = !(now_q < rd_q.delay_until) && (elapsed >= rd_q.interval);
    stat_o.last_idx   = (idx_nxt == count_q);
    stat_o.next_last  = (idx_nxt2 == {1'b0, count_q});
    stat_o.pend_vld   = pend_vld_q;
    stat_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign status_ok_o = status_ok_q;
  assign fired_o     = fired_q;
  assign fired_id_o  = fired_id_q;
  assign last_o      = last_q;

endmodule

@@ src/pst_ctrl.sv @@
// Controller state machine that sequences table searches, shifts and scans.
`timescale 1ns / 1ps

module pst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pst_pkg::pst_stat_t stat_i,
  output pst_pkg::pst_cmd_t  cmd_o
);
  import pst_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_START  = 9'b000000010,
    S_READ   = 9'b000000100,
    S_EVAL   = 9'b000001000,
    S_SHRD   = 9'b000010000,
    S_SHWR   = 9'b000100000,
    S_DROP   = 9'b001000000,
    S_APPEND = 9'b010000000,
    S_FINAL  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_START;
        end
      end
      S_START: begin
        priority if (stat_i.mode == MODE_CREATE && stat_i.create_bad) begin
          state_d = S_FINAL;
        end else if (stat_i.cnt_zero) begin
          state_d = (stat_i.mode == MODE_CREATE) ? S_APPEND : S_FINAL;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        unique case (stat_i.mode)
          MODE_RUN: begin
            // Hold while a pending report cannot be pushed out.
            if (!(stat_i.due && stat_i.pend_vld && !stat_i.out_free)) begin
              if (stat_i.due) begin
                cmd_o.wr_sel   = WR_FIRE;
                cmd_o.pend_set = 1'b1;
                if (stat_i.pend_vld) cmd_o.out_sel = OUT_PEND;
              end
              if (stat_i.last_idx) begin
                state_d = S_FINAL;
              end else begin
                cmd_o.idx_inc = 1'b1;
                state_d       = S_READ;
              end
            end
          end
          MODE_DELETE: begin
            priority if (stat_i.match) begin
              state_d = stat_i.last_idx ? S_DROP : S_SHRD;
            end else if (stat_i.last_idx) begin
              state_d = S_FINAL;
            end else begin
              cmd_o.idx_inc = 1'b1;
              state_d       = S_READ;
            end
          end
          MODE_DELAY: begin
            priority if (stat_i.match) begin
              cmd_o.wr_sel = WR_DELAY;
              cmd_o.ok_set = 1'b1;
              state_d      = S_FINAL;
            end else if (stat_i.last_idx) begin
              state_d = S_FINAL;
            end else begin
              cmd_o.idx_inc = 1'b1;
              state_d       = S_READ;
            end
          end
          MODE_CREATE: begin
            priority if (stat_i.match) begin
              state_d = S_FINAL;
            end else if (stat_i.last_idx) begin
              state_d = S_APPEND;
            end else begin
              cmd_o.idx_inc = 1'b1;
              state_d       = S_READ;
            end
          end
          default: state_d = S_FINAL;
        endcase
      end
      S_SHRD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_next = 1'b1;
        state_d       = S_SHWR;
      end
      S_SHWR: begin
        // Copy the later entry down one slot and advance.
        cmd_o.wr_sel  = WR_SHIFT;
        cmd_o.idx_inc = 1'b1;
        state_d       = stat_i.next_last ? S_DROP : S_SHRD;
      end
      S_DROP: begin
        cmd_o.cnt_dec = 1'b1;
        cmd_o.ok_set  = 1'b1;
        state_d       = S_FINAL;
      end
      S_APPEND: begin
        cmd_o.wr_sel  = WR_APPEND;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.ok_set  = 1'b1;
        state_d       = S_FINAL;
      end
      S_FINAL: begin
        if (stat_i.out_free) begin
          cmd_o.out_sel = OUT_FINAL;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
